// ----- rtl/rhh_pkg.sv -----
// Shared types and constants for the Robin Hood hash table.
package rhh_pkg;

    localparam int DEF_SLOTS      = 256;
    localparam int DEF_KEY_BITS   = 32;
    localparam int DEF_VALUE_BITS = 32;
    localparam int MAX_LIVE       = 256;
    localparam int HASH_BITS      = 32;

    localparam logic [1:0] KIND_LOOKUP = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    localparam logic [1:0] STAT_DONE     = 2'd0;
    localparam logic [1:0] STAT_NOTFOUND = 2'd1;
    localparam logic [1:0] STAT_EXISTS   = 2'd2;
    localparam logic [1:0] STAT_FULL     = 2'd3;

    localparam logic REG_SLOTS_USED  = 1'b0;
    localparam logic REG_MAX_ENTRIES = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_DISPATCH,
        ST_F_CHK,
        ST_F_WAIT,
        ST_F_EV,
        ST_R_CHK,
        ST_R_WAIT,
        ST_R_EV,
        ST_I_CHK,
        ST_I_WAIT,
        ST_I_EV,
        ST_DONE
    } state_t;

endpackage

// ----- rtl/robin_hood_hash_table_top.sv -----
// Robin Hood hash table top level: stream ports, APB registers, sequencer and slot memory.
//
// One transaction at a time. After an item is accepted the home slot is formed by a
// bit-serial remainder unit (one hash bit per cycle), then each probed slot passes
// through check, wait and evaluate states around the single registered read port of
// the slot memory; a remove goes through them again for each entry shifted back.
// s_tready is high only between items; a finished result sits in the output register
// while the next item is accepted.
// Valid bits are flip-flops cleared at reset, so no clearing pass is needed.
module robin_hood_hash_table_top #(
    parameter int SLOTS      = rhh_pkg::DEF_SLOTS,
    parameter int KEY_BITS   = rhh_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS = rhh_pkg::DEF_VALUE_BITS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // kind[1:0], key_hash[33:2], key[65:34], value[97:66], zero fill
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], value_out[33:2], slot_index[41:34], entry_count[50:42], zero fill
    output logic [55:0]  m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int DEPTH = (SLOTS < rhh_pkg::MAX_LIVE) ? SLOTS : rhh_pkg::MAX_LIVE;
    localparam int AW    = $clog2(DEPTH);

    // configuration
    logic [8:0] slots_reg;
    logic [7:0] max_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == rhh_pkg::REG_SLOTS_USED) ? {23'd0, slots_reg}
                                                          : {24'd0, max_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slots_reg <= 9'd256;
            max_reg   <= 8'd192;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == rhh_pkg::REG_SLOTS_USED) slots_reg <= pwdata[8:0];
            else                                     max_reg   <= pwdata[7:0];
        end
    end

    logic [8:0] n_w;
    always_comb begin
        n_w = slots_reg;
        if (n_w == 9'd0) n_w = 9'd1;
        if (n_w > 9'd256) n_w = 9'd256;
        if (n_w > 9'(DEPTH)) n_w = 9'(DEPTH);
    end

    // slot memory
    logic [KEY_BITS-1:0]   mem_key [DEPTH];
    logic [VALUE_BITS-1:0] mem_val [DEPTH];
    logic [7:0]            mem_prb [DEPTH];
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_val;
    logic [7:0]            rd_prb;
    logic                  we;
    logic [AW-1:0]         wa;
    logic [KEY_BITS-1:0]   wk;
    logic [VALUE_BITS-1:0] wv;
    logic [7:0]            wp;

    // sequencer registers
    rhh_pkg::state_t state_reg, state_next;
    logic [DEPTH-1:0]      valid_reg, valid_next;
    logic [8:0]            cnt_reg, cnt_next;
    logic [7:0]            longest_reg, longest_next;
    logic [1:0]            kind_reg, kind_next;
    logic [31:0]           hash_reg, hash_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [KEY_BITS-1:0]   ck_reg, ck_next;
    logic [VALUE_BITS-1:0] cv_reg, cv_next;
    logic [7:0]            cp_reg, cp_next;
    logic                  carry_reg, carry_next;
    logic [8:0]            rem_reg, rem_next;
    logic [5:0]            bit_reg, bit_next;
    logic [AW-1:0]         s_reg, s_next;
    logic [AW-1:0]         ra_reg, ra_next;
    logic [8:0]            p_reg, p_next;
    logic [1:0]            st_reg, st_next;
    logic [31:0]           vo_reg, vo_next;
    logic [AW-1:0]         idx_reg, idx_next;
    logic                  mv_reg, mv_next;
    logic [55:0]           md_reg, md_next;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_key[wa] <= wk;
            mem_val[wa] <= wv;
            mem_prb[wa] <= wp;
        end
        rd_key <= mem_key[ra_reg];
        rd_val <= mem_val[ra_reg];
        rd_prb <= mem_prb[ra_reg];
    end

    logic [AW-1:0] s_inc;
    logic [AW-1:0] ra_inc;
    logic [9:0]    trial;
    logic [7:0]    cp_new;

    assign s_inc  = (9'(s_reg) + 9'd1 == n_w) ? '0 : AW'(9'(s_reg) + 9'd1);
    assign ra_inc = s_inc;
    assign trial  = {rem_reg, hash_reg[31]};

    assign s_tready = (state_reg == rhh_pkg::ST_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;

    always_comb begin
        state_next   = state_reg;
        valid_next   = valid_reg;
        cnt_next     = cnt_reg;
        longest_next = longest_reg;
        kind_next    = kind_reg;
        hash_next    = hash_reg;
        key_next     = key_reg;
        ck_next      = ck_reg;
        cv_next      = cv_reg;
        cp_next      = cp_reg;
        carry_next   = carry_reg;
        rem_next     = rem_reg;
        bit_next     = bit_reg;
        s_next       = s_reg;
        ra_next      = ra_reg;
        p_next       = p_reg;
        st_next      = st_reg;
        vo_next      = vo_reg;
        idx_next     = idx_reg;
        mv_next      = mv_reg;
        md_next      = md_reg;
        we           = 1'b0;
        wa           = s_reg;
        wk           = ck_reg;
        wv           = cv_reg;
        wp           = cp_reg;
        cp_new       = cp_reg;

        if (mv_reg && m_tready) mv_next = 1'b0;

        case (state_reg)
            rhh_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next  = s_tdata[1:0];
                    hash_next  = s_tdata[33:2];
                    key_next   = KEY_BITS'(s_tdata[65:34]);
                    ck_next    = KEY_BITS'(s_tdata[65:34]);
                    cv_next    = VALUE_BITS'(s_tdata[97:66]);
                    rem_next   = 9'd0;
                    bit_next   = 6'd0;
                    st_next    = rhh_pkg::STAT_NOTFOUND;
                    vo_next    = 32'd0;
                    idx_next   = '0;
                    state_next = rhh_pkg::ST_MOD;
                end
            end
            rhh_pkg::ST_MOD: begin
                // restoring remainder, one hash bit per cycle
                if (trial >= {1'b0, n_w}) rem_next = 9'(trial - {1'b0, n_w});
                else                      rem_next = trial[8:0];
                hash_next = {hash_reg[30:0], 1'b0};
                bit_next  = bit_reg + 6'd1;
                if (bit_reg == 6'(rhh_pkg::HASH_BITS - 1)) state_next = rhh_pkg::ST_DISPATCH;
            end
            rhh_pkg::ST_DISPATCH: begin
                s_next = AW'(rem_reg);
                p_next = 9'd0;
                case (kind_reg)
                    rhh_pkg::KIND_LOOKUP, rhh_pkg::KIND_REMOVE: state_next = rhh_pkg::ST_F_CHK;
                    rhh_pkg::KIND_INSERT: begin
                        if (cnt_reg >= {1'b0, max_reg} || cnt_reg >= n_w) begin
                            st_next    = rhh_pkg::STAT_FULL;
                            state_next = rhh_pkg::ST_DONE;
                        end else begin
                            cp_next    = 8'd0;
                            carry_next = 1'b1;
                            state_next = rhh_pkg::ST_I_CHK;
                        end
                    end
                    default: state_next = rhh_pkg::ST_DONE;
                endcase
            end
            rhh_pkg::ST_F_CHK: begin
                if (p_reg > {1'b0, longest_reg}) begin
                    state_next = rhh_pkg::ST_DONE;
                end else begin
                    ra_next    = s_reg;
                    state_next = rhh_pkg::ST_F_WAIT;
                end
            end
            rhh_pkg::ST_F_WAIT: state_next = rhh_pkg::ST_F_EV;
            rhh_pkg::ST_F_EV: begin
                if (!valid_reg[s_reg] || p_reg > {1'b0, rd_prb}) begin
                    state_next = rhh_pkg::ST_DONE;
                end else if (rd_key == key_reg) begin
                    st_next  = rhh_pkg::STAT_DONE;
                    vo_next  = 32'(rd_val);
                    idx_next = s_reg;
                    if (kind_reg == rhh_pkg::KIND_REMOVE) begin
                        if (cnt_reg != 9'd0) cnt_next = cnt_reg - 9'd1;
                        p_next     = 9'd0;
                        state_next = rhh_pkg::ST_R_CHK;
                    end else begin
                        state_next = rhh_pkg::ST_DONE;
                    end
                end else begin
                    s_next     = s_inc;
                    p_next     = p_reg + 9'd1;
                    state_next = rhh_pkg::ST_F_CHK;
                end
            end
            rhh_pkg::ST_R_CHK: begin
                // p_reg counts shifted entries here
                if (p_reg + 9'd1 < n_w) begin
                    ra_next    = ra_inc;
                    state_next = rhh_pkg::ST_R_WAIT;
                end else begin
                    valid_next[s_reg] = 1'b0;
                    state_next        = rhh_pkg::ST_DONE;
                end
            end
            rhh_pkg::ST_R_WAIT: state_next = rhh_pkg::ST_R_EV;
            rhh_pkg::ST_R_EV: begin
                if (!valid_reg[ra_reg] || rd_prb == 8'd0) begin
                    valid_next[s_reg] = 1'b0;
                    state_next        = rhh_pkg::ST_DONE;
                end else begin
                    we         = 1'b1;
                    wk         = rd_key;
                    wv         = rd_val;
                    wp         = rd_prb - 8'd1;
                    s_next     = ra_reg;
                    p_next     = p_reg + 9'd1;
                    state_next = rhh_pkg::ST_R_CHK;
                end
            end
            rhh_pkg::ST_I_CHK: begin
                // p_reg counts probed slots here
                if (p_reg < n_w) begin
                    ra_next    = s_reg;
                    state_next = rhh_pkg::ST_I_WAIT;
                end else begin
                    st_next    = rhh_pkg::STAT_FULL;
                    idx_next   = '0;
                    state_next = rhh_pkg::ST_DONE;
                end
            end
            rhh_pkg::ST_I_WAIT: state_next = rhh_pkg::ST_I_EV;
            rhh_pkg::ST_I_EV: begin
                if (!valid_reg[s_reg]) begin
                    if (cp_reg > longest_reg) longest_next = cp_reg;
                    we                = 1'b1;
                    valid_next[s_reg] = 1'b1;
                    cnt_next          = cnt_reg + 9'd1;
                    if (carry_reg) idx_next = s_reg;
                    st_next    = rhh_pkg::STAT_DONE;
                    state_next = rhh_pkg::ST_DONE;
                end else if (carry_reg && rd_key == key_reg) begin
                    st_next    = rhh_pkg::STAT_EXISTS;
                    vo_next    = 32'(rd_val);
                    idx_next   = s_reg;
                    state_next = rhh_pkg::ST_DONE;
                end else begin
                    if (cp_reg > rd_prb) begin
                        // displace the richer resident, carry it onward
                        if (cp_reg > longest_reg) longest_next = cp_reg;
                        we      = 1'b1;
                        ck_next = rd_key;
                        cv_next = rd_val;
                        cp_new  = rd_prb;
                        if (carry_reg) begin
                            idx_next   = s_reg;
                            carry_next = 1'b0;
                        end
                    end
                    cp_next    = (cp_new != 8'd255) ? cp_new + 8'd1 : cp_new;
                    s_next     = s_inc;
                    p_next     = p_reg + 9'd1;
                    state_next = rhh_pkg::ST_I_CHK;
                end
            end
            rhh_pkg::ST_DONE: begin
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    md_next    = {5'd0, cnt_reg, 8'(idx_reg), vo_reg, st_reg};
                    state_next = rhh_pkg::ST_IDLE;
                end
            end
            default: state_next = rhh_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rhh_pkg::ST_IDLE;
            valid_reg   <= '0;
            cnt_reg     <= 9'd0;
            longest_reg <= 8'd0;
            mv_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            cnt_reg     <= cnt_next;
            longest_reg <= longest_next;
            mv_reg      <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        hash_reg  <= hash_next;
        key_reg   <= key_next;
        ck_reg    <= ck_next;
        cv_reg    <= cv_next;
        cp_reg    <= cp_next;
        carry_reg <= carry_next;
        rem_reg   <= rem_next;
        bit_reg   <= bit_next;
        s_reg     <= s_next;
        ra_reg    <= ra_next;
        p_reg     <= p_next;
        st_reg    <= st_next;
        vo_reg    <= vo_next;
        idx_reg   <= idx_next;
        md_reg    <= md_next;
    end

    // a remove drops the count before its shift pass clears the last slot
    a_count_matches_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == rhh_pkg::ST_IDLE |-> $countones(valid_reg) == int'(cnt_reg))
        else $error("entry count differs from number of valid slots");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 9'(DEPTH))
        else $error("entry count above table depth");

    a_accept_starts_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == rhh_pkg::ST_MOD)
        else $error("accepted transaction did not start home slot computation");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == rhh_pkg::ST_DONE))
        else $error("result raised outside done state");

endmodule
